// ===== design/hdp_pkg.sv =====
// ----------------------------------------------------------------------------
// hdp_pkg: shared types and constants of the HTTP date parser
// Word types of both channels, scanner phases, controller states, the month
// name string and the calendar tables used by the date arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package hdp_pkg;

	// Longest number a field may hold, leading zeros included
	localparam int MAX_DIGITS = 6;
	localparam int ACC_W      = $clog2(10 ** MAX_DIGITS);
	localparam int DC_W       = $clog2(MAX_DIGITS + 1);
	// Signed field width
	localparam int FW         = ACC_W + 1;

	// Configuration
	localparam int CFG_W  = 14;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic [CFG_W-1:0] YEAR_MIN_RST = 14'd2025;
	localparam logic [CFG_W-1:0] YEAR_MAX_RST = 14'd2100;
	localparam logic REG_YEAR_MIN = 1'b0;
	localparam logic REG_YEAR_MAX = 1'b1;

	// Date arithmetic pipeline depth after the snapshot
	localparam int CALC_STAGES = 5;
	localparam int CNT_W       = $clog2(CALC_STAGES);

	localparam int OUT_W = 41;

	// Month names, padded with two zero bytes so a three byte compare at the
	// last offset stays in range and never matches
	localparam logic [8*38-1:0] MONTH_NAMES = {"JanFebMarAprMayJunJulAugSepOctNovDec", 16'h0000};

	typedef struct packed {
		logic [7:0] character;
		logic       end_of_text;
	} hdr_word_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] epoch_seconds;
		logic                    date_ok;
	} epoch_word_t;

	typedef enum logic [3:0] {
		PH_COMMA,
		PH_DAY,
		PH_MON,
		PH_YEAR,
		PH_HOUR,
		PH_COLON1,
		PH_MIN,
		PH_COLON2,
		PH_SEC,
		PH_DONE,
		PH_STOP
	} scan_phase_t;

	typedef enum logic [1:0] {
		ST_SCAN,
		ST_CALC,
		ST_LOAD
	} ctrl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic step;
		logic load;
	} hdp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic last;
	} hdp_stat_t;

	// Finished scan handed to the date arithmetic
	typedef struct packed {
		logic                 done;
		logic [2:0][7:0]      tok;
		logic [1:0]           tlen;
		logic signed [FW-1:0] day;
		logic signed [FW-1:0] year;
		logic signed [FW-1:0] hour;
		logic signed [FW-1:0] minute;
		logic signed [FW-1:0] second;
	} hdp_snap_t;

	function automatic logic [7:0] name_char(input int p);
		return MONTH_NAMES[8*(37-p) +: 8];
	endfunction

	// First month whose name string offset holds the token, 0 when none
	function automatic logic [3:0] month_of(input logic [2:0][7:0] tok, input logic [1:0] tlen);
		logic [3:0] m;
		logic       hit;
		int         i;
		int         k;
		int         p;
		m = '0;
		for (i = 0; i < 12; i++) begin
			for (k = 0; k < 3; k++) begin
				p = 3 * i + k;
				hit = (tlen != 2'd0) && (name_char(p) == tok[0])
					&& (tlen < 2'd2 || name_char(p + 1) == tok[1])
					&& (tlen < 2'd3 || name_char(p + 2) == tok[2]);
				if (hit && m == '0) begin
					m = 4'(i + 1);
				end
			end
		end
		return m;
	endfunction

	// Days from March 1 to the first of the month
	function automatic logic [8:0] cum_days(input logic [3:0] month);
		logic [8:0] d;
		unique case (month)
			4'd3:    d = 9'd0;
			4'd4:    d = 9'd31;
			4'd5:    d = 9'd61;
			4'd6:    d = 9'd92;
			4'd7:    d = 9'd122;
			4'd8:    d = 9'd153;
			4'd9:    d = 9'd184;
			4'd10:   d = 9'd214;
			4'd11:   d = 9'd245;
			4'd12:   d = 9'd275;
			4'd1:    d = 9'd306;
			4'd2:    d = 9'd337;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

`default_nettype wire

// ===== design/http_date_to_epoch_parser.sv =====
// ----------------------------------------------------------------------------
// http_date_to_epoch_parser: HTTP Date header to Unix seconds
// Header text enters on the hdr channel, one byte per word, with end_of_text
// set on the final byte. One result word leaves on the epoch channel for each
// header: signed epoch_seconds and date_ok, seconds 0 when the parse fails.
// Bytes are taken at one per cycle. After the final byte hdr_ready stays low
// while the five-stage date pipeline runs and until the result is offered;
// the next header can start then.
// The result sits in an output register. If the receiver stalls, the next
// header is still scanned; only its final byte's result waits for the slot,
// with hdr_ready low until the held word is taken.
// Year bounds sit behind the APB port at 0x0 (year_min) and 0x4 (year_max).
// Reset returns the scanner to the comma search, empties the output and sets
// the bounds to 2025 and 2100.
// ----------------------------------------------------------------------------
`default_nettype none

module http_date_to_epoch_parser import hdp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              hdr_valid,
	output logic                   hdr_ready,
	input  wire hdr_word_t         hdr,
	output logic                   epoch_valid,
	input  wire logic              epoch_ready,
	output epoch_word_t            epoch,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready
);

	logic [CFG_W-1:0] year_min_q;
	logic [CFG_W-1:0] year_max_q;
	logic             cfg_wr;
	hdp_cmd_t         cmd;
	hdp_stat_t        stat;
	hdp_snap_t        snap;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Write the year bounds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_min_q <= YEAR_MIN_RST;
			year_max_q <= YEAR_MAX_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_YEAR_MIN: year_min_q <= pwdata[CFG_W-1:0];
				REG_YEAR_MAX: year_max_q <= pwdata[CFG_W-1:0];
				default:      year_min_q <= year_min_q;
			endcase
		end
	end

	// Read back; unaligned addresses read zero
	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			unique case (paddr[2])
				REG_YEAR_MIN: prdata = {{(DATA_W-CFG_W){1'b0}}, year_min_q};
				REG_YEAR_MAX: prdata = {{(DATA_W-CFG_W){1'b0}}, year_max_q};
				default:      prdata = '0;
			endcase
		end
	end

	hdp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.hdr_valid   (hdr_valid),
		.hdr_ready   (hdr_ready),
		.epoch_valid (epoch_valid),
		.epoch_ready (epoch_ready),
		.stat        (stat),
		.cmd         (cmd)
	);

	hdp_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.hdr    (hdr),
		.stat   (stat),
		.snap   (snap)
	);

	hdp_date u_date (
		.clk      (clk),
		.cmd      (cmd),
		.snap     (snap),
		.year_min (year_min_q),
		.year_max (year_max_q),
		.epoch    (epoch)
	);

endmodule

`default_nettype wire

// ===== design/hdp_scan.sv =====
// ----------------------------------------------------------------------------
// hdp_scan: header byte scanner
// Skips to the first comma, then scans day, month token, year and
// hour:minute:second one byte per step, and snapshots the finished fields on
// the last byte of the header.
// ----------------------------------------------------------------------------
`default_nettype none

module hdp_scan import hdp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire hdp_cmd_t  cmd,
	input  wire hdr_word_t hdr,
	output hdp_stat_t      stat,
	output hdp_snap_t      snap
);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	typedef struct packed {
		scan_phase_t          phase;
		logic [ACC_W-1:0]     acc;
		logic                 neg;
		logic                 begun;
		logic [DC_W-1:0]      dcnt;
		logic signed [FW-1:0] day;
		logic signed [FW-1:0] year;
		logic signed [FW-1:0] hour;
		logic signed [FW-1:0] minute;
		logic signed [FW-1:0] second;
		logic [2:0][7:0]      tok;
		logic [1:0]           tlen;
		logic                 failed;
	} scan_t;

	typedef struct packed {
		scan_t st;
		logic  redo;
	} step_t;

	scan_t     scan_q;
	scan_t     scan_d;
	scan_t     s_byte;
	scan_t     s_fin;
	step_t     p1;
	step_t     p2;
	hdp_snap_t snap_q;
	hdp_snap_t snap_d;

	function automatic logic is_ws(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic scan_t enter(input scan_t s, input scan_phase_t ph);
		scan_t r;
		r       = s;
		r.phase = ph;
		r.acc   = '0;
		r.neg   = 1'b0;
		r.begun = 1'b0;
		r.dcnt  = '0;
		return r;
	endfunction

	function automatic scan_t clear_scan();
		scan_t r;
		r       = '0;
		r.phase = PH_COMMA;
		return r;
	endfunction

	function automatic scan_t fail_scan(input scan_t s);
		scan_t r;
		r        = s;
		r.failed = 1'b1;
		r.phase  = PH_STOP;
		return r;
	endfunction

	// Write the finished number into the field of the current phase
	function automatic scan_t store_number(input scan_t s);
		scan_t                r;
		logic signed [FW-1:0] v;
		r = s;
		v = $signed({1'b0, s.acc});
		if (s.neg) begin
			v = -v;
		end
		unique case (s.phase)
			PH_DAY:  r.day    = v;
			PH_YEAR: r.year   = v;
			PH_HOUR: r.hour   = v;
			PH_MIN:  r.minute = v;
			PH_SEC:  r.second = v;
			default: r = s;
		endcase
		return r;
	endfunction

	function automatic scan_phase_t next_phase(input scan_phase_t ph);
		scan_phase_t n;
		unique case (ph)
			PH_DAY:  n = PH_MON;
			PH_YEAR: n = PH_HOUR;
			PH_HOUR: n = PH_COLON1;
			PH_MIN:  n = PH_COLON2;
			PH_SEC:  n = PH_DONE;
			default: n = PH_STOP;
		endcase
		return n;
	endfunction

	// One byte in a number field; redo when the byte closes the number
	function automatic step_t number_byte(input scan_t s, input logic [7:0] c);
		step_t r;
		r.st   = s;
		r.redo = 1'b0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			if (s.dcnt >= DC_W'(MAX_DIGITS)) begin
				r.st = fail_scan(s);
			end else begin
				r.st.acc   = ACC_W'(s.acc * ACC_W'(10) + {{(ACC_W-4){1'b0}}, c[3:0]});
				r.st.dcnt  = DC_W'(s.dcnt + 1'b1);
				r.st.begun = 1'b1;
			end
		end else if (!s.begun) begin
			if (c == CH_PLUS || c == CH_MINUS) begin
				r.st.begun = 1'b1;
				r.st.neg   = (c == CH_MINUS);
			end else if (!is_ws(c)) begin
				r.st = fail_scan(s);
			end
		end else if (s.dcnt == '0) begin
			r.st = fail_scan(s);
		end else begin
			r.st   = enter(store_number(s), next_phase(s.phase));
			r.redo = 1'b1;
		end
		return r;
	endfunction

	function automatic step_t step_byte(input scan_t s, input logic [7:0] c);
		step_t r;
		r.st   = s;
		r.redo = 1'b0;
		unique case (s.phase)
			PH_COMMA: begin
				if (c == CH_COMMA) begin
					r.st = enter(s, PH_DAY);
				end
			end
			PH_DAY, PH_YEAR, PH_HOUR, PH_MIN, PH_SEC: begin
				r = number_byte(s, c);
			end
			PH_MON: begin
				if (is_ws(c)) begin
					if (s.tlen != 2'd0) begin
						r.st   = enter(s, PH_YEAR);
						r.redo = 1'b1;
					end
				end else begin
					r.st.tok[s.tlen] = c;
					r.st.tlen        = 2'(s.tlen + 1'b1);
					if (s.tlen == 2'd2) begin
						r.st = enter(r.st, PH_YEAR);
					end
				end
			end
			PH_COLON1: begin
				r.st = (c == CH_COLON) ? enter(s, PH_MIN) : fail_scan(s);
			end
			PH_COLON2: begin
				r.st = (c == CH_COLON) ? enter(s, PH_SEC) : fail_scan(s);
			end
			default: begin
				r.st = s;
			end
		endcase
		return r;
	endfunction

	// Close the text: pending second digits complete the last field
	function automatic scan_t finish_scan(input scan_t s);
		scan_t r;
		r = s;
		if (s.phase == PH_SEC && s.dcnt != '0) begin
			r = enter(store_number(s), PH_DONE);
		end else if (s.phase != PH_DONE) begin
			r = fail_scan(s);
		end
		return r;
	endfunction

	// Advance the scan by one byte. A byte that closes a field is seen once
	// more by the next phase; that second look never asks for a third.
	always_comb begin
		s_byte = scan_q;
		p1     = step_byte(scan_q, hdr.character);
		p2     = step_byte(p1.st, hdr.character);
		if (scan_q.phase != PH_DONE && scan_q.phase != PH_STOP) begin
			if (hdr.character == CH_NUL) begin
				s_byte = finish_scan(scan_q);
			end else begin
				s_byte = p1.redo ? p2.st : p1.st;
			end
		end
		s_fin = finish_scan(s_byte);

		scan_d = scan_q;
		if (cmd.step) begin
			scan_d = hdr.end_of_text ? clear_scan() : s_byte;
		end

		snap_d.done   = (s_fin.phase == PH_DONE);
		snap_d.tok    = s_fin.tok;
		snap_d.tlen   = s_fin.tlen;
		snap_d.day    = s_fin.day;
		snap_d.year   = s_fin.year;
		snap_d.hour   = s_fin.hour;
		snap_d.minute = s_fin.minute;
		snap_d.second = s_fin.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= clear_scan();
		end else begin
			scan_q <= scan_d;
		end
	end

	// Hold the finished fields for the date arithmetic
	always_ff @(posedge clk) begin
		if (cmd.step && hdr.end_of_text) begin
			snap_q <= snap_d;
		end
	end

	assign snap      = snap_q;
	assign stat.last = hdr.end_of_text;

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && hdr.end_of_text) |=> (scan_q.phase == PH_COMMA && !scan_q.failed
			&& scan_q.tlen == 2'd0))
		else $error("scanner not cleared after last word");

	a_stop_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_q.phase == PH_STOP && !(cmd.step && hdr.end_of_text)) |=> scan_q.phase == PH_STOP)
		else $error("failed scan left stop phase before end of text");

endmodule

`default_nettype wire

// ===== design/hdp_date.sv =====
// ----------------------------------------------------------------------------
// hdp_date: days-from-civil arithmetic
// Five register stages from the scan snapshot to epoch seconds: month match
// and year check, era, year of era, day count, seconds. Holds the result
// word for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module hdp_date import hdp_pkg::*; (
	input  wire logic             clk,
	input  wire hdp_cmd_t         cmd,
	input  wire hdp_snap_t        snap,
	input  wire logic [CFG_W-1:0] year_min,
	input  wire logic [CFG_W-1:0] year_max,
	output epoch_word_t           epoch
);

	localparam int HS_W  = FW + 13;
	localparam int HMS_W = FW + 14;
	localparam int DYW   = (FW > 23) ? FW + 2 : 25;
	localparam int PW    = DYW + 17;
	// y / 400 for 0 <= y < 10000 as a multiply and shift
	localparam logic [12:0] ERA_RECIP = 13'd5243;
	localparam int          ERA_SHIFT = 21;
	// yoe / 100 for yoe < 400
	localparam logic [5:0]  CENT_RECIP = 6'd41;
	localparam int          CENT_SHIFT = 12;

	localparam logic signed [12:0] SEC_PER_HOUR = 13'sd3600;
	localparam logic signed [7:0]  SEC_PER_MIN  = 8'sd60;
	localparam logic signed [10:0] YEARS_PER_ERA = 11'sd400;
	localparam logic signed [18:0] DAYS_PER_ERA = 19'sd146097;
	localparam logic signed [9:0]  DAYS_PER_YEAR = 10'sd365;
	localparam logic signed [20:0] EPOCH_SHIFT = 21'sd719468;
	localparam logic signed [17:0] SEC_PER_DAY = 18'sd86400;
	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	logic [3:0]           month;
	logic                 jan_feb;
	logic                 year_in;
	logic signed [FW-1:0] ymin_x;
	logic signed [FW-1:0] ymax_x;

	logic                    ok_s1;
	logic signed [14:0]      y_s1;
	logic signed [FW+1:0]    doy_s1;
	logic signed [HS_W-1:0]  hsec_s1;
	logic signed [FW+7:0]    msec_s1;
	logic signed [FW-1:0]    sec_s1;

	logic [26:0]             era_prod;
	logic                    ok_s2;
	logic signed [5:0]       era_s2;
	logic signed [14:0]      y_s2;
	logic signed [FW+1:0]    doy_s2;
	logic signed [HMS_W-1:0] hms_s2;

	logic signed [14:0]      yoe_w;
	logic                    ok_s3;
	logic [8:0]              yoe_s3;
	logic signed [5:0]       era_s3;
	logic signed [FW+1:0]    doy_s3;
	logic signed [HMS_W-1:0] hms_s3;

	logic [14:0]             cent_prod;
	logic                    ok_s4;
	logic signed [DYW-1:0]   days_s4;
	logic signed [HMS_W-1:0] hms_s4;

	logic                    ok_s5;
	logic signed [PW-1:0]    prod_s5;
	logic signed [HMS_W-1:0] hms_s5;

	logic signed [PW:0]      secs_w;
	logic signed [OUT_W-1:0] secs_sat;
	epoch_word_t             epoch_d;
	epoch_word_t             epoch_q;

	// Month match, year bounds, March-based day of year
	always_comb begin
		month   = month_of(snap.tok, snap.tlen);
		jan_feb = (month == 4'd1) || (month == 4'd2);
		ymin_x  = $signed({{(FW-CFG_W){1'b0}}, year_min});
		ymax_x  = $signed({{(FW-CFG_W){1'b0}}, year_max});
		year_in = (snap.year >= ymin_x) && (snap.year <= ymax_x);
	end

	always_ff @(posedge clk) begin
		ok_s1   <= snap.done && (month != 4'd0) && year_in;
		y_s1    <= $signed({1'b0, snap.year[CFG_W-1:0]}) - $signed({1'b0, jan_feb});
		doy_s1  <= snap.day + $signed({1'b0, cum_days(month)}) - 2'sd1;
		hsec_s1 <= snap.hour * SEC_PER_HOUR;
		msec_s1 <= snap.minute * SEC_PER_MIN;
		sec_s1  <= snap.second;
	end

	// Era: floor of the shifted year over 400
	assign era_prod = 27'(y_s1[13:0]) * 27'(ERA_RECIP);

	always_ff @(posedge clk) begin
		ok_s2  <= ok_s1;
		era_s2 <= y_s1[14] ? -6'sd1 : $signed({1'b0, era_prod[ERA_SHIFT +: 5]});
		y_s2   <= y_s1;
		doy_s2 <= doy_s1;
		hms_s2 <= hsec_s1 + msec_s1 + sec_s1;
	end

	// Year of era
	assign yoe_w = y_s2 - era_s2 * YEARS_PER_ERA;

	always_ff @(posedge clk) begin
		ok_s3  <= ok_s2;
		yoe_s3 <= yoe_w[8:0];
		era_s3 <= era_s2;
		doy_s3 <= doy_s2;
		hms_s3 <= hms_s2;
	end

	// Days since the epoch
	assign cent_prod = 15'(yoe_s3) * 15'(CENT_RECIP);

	always_ff @(posedge clk) begin
		ok_s4   <= ok_s3;
		days_s4 <= era_s3 * DAYS_PER_ERA
			+ $signed({1'b0, yoe_s3}) * DAYS_PER_YEAR
			+ $signed({3'b000, yoe_s3[8:2]})
			- $signed({1'b0, cent_prod[CENT_SHIFT +: 3]})
			+ doy_s3
			- EPOCH_SHIFT;
		hms_s4  <= hms_s3;
	end

	always_ff @(posedge clk) begin
		ok_s5   <= ok_s4;
		prod_s5 <= days_s4 * SEC_PER_DAY;
		hms_s5  <= hms_s4;
	end

	// Add the time of day and clamp to the output range; the clamp only
	// engages with a digit limit large enough for extreme day values
	always_comb begin
		secs_w = prod_s5 + hms_s5;
		if (secs_w > OUT_MAX) begin
			secs_sat = OUT_MAX;
		end else if (secs_w < OUT_MIN) begin
			secs_sat = OUT_MIN;
		end else begin
			secs_sat = secs_w[OUT_W-1:0];
		end
		epoch_d.epoch_seconds = ok_s5 ? secs_sat : '0;
		epoch_d.date_ok       = ok_s5;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			epoch_q <= epoch_d;
		end
	end

	assign epoch = epoch_q;

endmodule

`default_nettype wire

// ===== design/hdp_ctrl.sv =====
// ----------------------------------------------------------------------------
// hdp_ctrl: parser controller
// Takes header words while scanning, waits out the date pipeline after the
// last word, and loads the result word when the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module hdp_ctrl import hdp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      hdr_valid,
	output logic           hdr_ready,
	output logic           epoch_valid,
	input  wire logic      epoch_ready,
	input  wire hdp_stat_t stat,
	output hdp_cmd_t       cmd
);

	ctrl_state_t      state_q;
	ctrl_state_t      state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] cnt_d;
	logic             out_valid_q;
	logic             out_valid_d;

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		hdr_ready = 1'b0;
		cmd       = '0;
		unique case (state_q)
			ST_SCAN: begin
				hdr_ready = 1'b1;
				cmd.step  = hdr_valid;
				if (hdr_valid && stat.last) begin
					state_d = ST_CALC;
					cnt_d   = '0;
				end
			end
			ST_CALC: begin
				if (cnt_q == CNT_W'(CALC_STAGES - 1)) begin
					state_d = ST_LOAD;
					cnt_d   = '0;
				end else begin
					cnt_d = CNT_W'(cnt_q + 1'b1);
				end
			end
			ST_LOAD: begin
				if (!out_valid_q || epoch_ready) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			default: begin
				state_d = ST_SCAN;
				cnt_d   = '0;
			end
		endcase

		// Raise on load, drop when taken
		if (cmd.load) begin
			out_valid_d = 1'b1;
		end else if (epoch_ready) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SCAN;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign epoch_valid = out_valid_q;

	a_stall_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && stat.last) |=> !hdr_ready)
		else $error("header word taken while date pipeline busy");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (epoch_valid && hdr_ready))
		else $error("loaded result not presented");

	a_cnt_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_CALC) |-> (cnt_q == '0))
		else $error("pipeline counter running outside calc");

endmodule

`default_nettype wire
